// ===== rtl/bdpc_pkg.sv =====
// Package for the button debounce and press classifier.
// Holds the item types, the per-button state entry, event codes and register constants.
// No dependencies.
package bdpc_pkg;

    // Event codes carried in press_event.
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_PRESS = 2'd1;
    localparam logic [1:0] EV_SHORT = 2'd2;
    localparam logic [1:0] EV_LONG  = 2'd3;

    // Configuration register indexes and reset values.
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_MS   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS_MS = 1'd1;
    localparam logic [CFG_DATA_W-1:0]  DEBOUNCE_MS_RST   = 16'd50;
    localparam logic [CFG_DATA_W-1:0]  LONG_PRESS_MS_RST = 16'd1000;

    // One input item: a sample of one button.
    typedef struct packed {
        logic [1:0]  button_index;
        logic        raw_level;
        logic [31:0] time_ms;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [1:0]  button_id;
        logic [1:0]  press_event;
        logic [31:0] hold_duration;
    } t_out_item;

    // State kept for each button in the state memory.
    typedef struct packed {
        logic        last_raw;
        logic        stable_level;
        logic [31:0] change_time;
        logic [31:0] press_start;
        logic        held_flag;
    } t_entry;

    // State of a button that has never been written since reset.
    localparam t_entry ENTRY_RST = '{
        last_raw:     1'b1,
        stable_level: 1'b1,
        change_time:  32'd0,
        press_start:  32'd0,
        held_flag:    1'b0
    };

endpackage

// ===== rtl/bdpc_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Used for the per-button state. No dependencies.
module bdpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; the output holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/button_debounce_press_classifier_core.sv =====
// Top level of the button debounce and press classifier.
// Depends on bdpc_pkg for types and constants and on bdpc_ram for the state memory.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item): one sample of one button,
//   with its index, raw pin level (0 = pressed) and the current millisecond time.
//   Output channel (o_out_valid / i_out_stall / o_out_item): exactly one result item
//   per sample, in order: the button index, an event code and the press duration.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 debounce_ms, 1 long_press_ms); write only while the block is idle.
// Timing:
//   An accepted sample reads its button's entry from the state memory on the accept
//   edge and is held in the stage 1 register; when stage 1 advances, the entry is
//   updated and written back and the result is registered in the output register.
//   Throughput is one item per cycle unless the output stalls: the memory read and
//   write-back are pipelined, and a same-cycle write to the entry read is forwarded.
// Reset:
//   Synchronous, active low. Per-button valid bits are cleared at once, so every
//   button reads as released with zero times; no clearing pass is needed. Both
//   registers return to 50 and 1000.
// Backpressure:
//   When i_out_stall holds a pending result, the stage behind it keeps its item and
//   o_in_stall rises only if that stage is also full.
module button_debounce_press_classifier_core #(
    parameter int BUTTON_COUNT = 4
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_in_valid,
    output logic                                      o_in_stall,
    input  bdpc_pkg::t_in_item                        i_in_item,
    output logic                                      o_out_valid,
    input  logic                                      i_out_stall,
    output bdpc_pkg::t_out_item                       o_out_item,
    input  logic                                      i_cfg_we,
    input  logic [bdpc_pkg::CFG_INDEX_W-1:0]          i_cfg_index,
    input  logic [bdpc_pkg::CFG_DATA_W-1:0]           i_cfg_data
);

    import bdpc_pkg::*;

    localparam int AW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
    localparam int EW = $bits(t_entry);

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_debounce_ms;
    logic [CFG_DATA_W-1:0] r_long_press_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms   <= DEBOUNCE_MS_RST;
            r_long_press_ms <= LONG_PRESS_MS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE_MS:   r_debounce_ms   <= i_cfg_data;
                CFG_LONG_PRESS_MS: r_long_press_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline control.
    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      s1_adv;
    logic      in_accept;

    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Address and range check for the incoming item.
    logic [31:0]   in_idx_ext;
    logic          in_in_range;
    logic [AW-1:0] in_addr;

    assign in_idx_ext  = 32'(i_in_item.button_index);
    assign in_in_range = in_idx_ext < 32'(BUTTON_COUNT);
    assign in_addr     = in_idx_ext[AW-1:0];

    // Address and range check for the item in the update stage.
    logic [31:0]   s1_idx_ext;
    logic          s1_in_range;
    logic [AW-1:0] s1_addr;

    assign s1_idx_ext  = 32'(r_s1_item.button_index);
    assign s1_in_range = s1_idx_ext < 32'(BUTTON_COUNT);
    assign s1_addr     = s1_idx_ext[AW-1:0];

    // State memory and per-entry valid bits.
    logic                    wr_en;
    t_entry                  wr_entry;
    logic [EW-1:0]           ram_rdata;
    logic [BUTTON_COUNT-1:0] r_init;

    assign wr_en = r_s1_valid && s1_adv && s1_in_range;

    bdpc_ram #(
        .WIDTH (EW),
        .DEPTH (BUTTON_COUNT)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (s1_addr),
        .i_wdata (wr_entry),
        .i_re    (in_accept && in_in_range),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
        end else if (wr_en) begin
            r_init[s1_addr] <= 1'b1;
        end
    end

    // Forwarding: the entry written on the same edge as a read of that entry.
    logic   r_byp_hit;
    t_entry r_byp_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else if (in_accept) begin
            r_byp_hit <= wr_en && in_in_range && (in_addr == s1_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_byp_entry <= wr_entry;
        end
    end

    // Stage 0 to stage 1 register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item <= i_in_item;
        end
    end

    // Update logic: pick the current entry, then debounce and classify.
    t_entry      cur;
    logic        raw_same;
    logic [31:0] elapsed;
    logic        level_taken;
    logic [31:0] held_time;
    logic [1:0]  n_event;
    logic [31:0] n_duration;

    always_comb begin
        if (r_byp_hit) begin
            cur = r_byp_entry;
        end else if (r_init[s1_addr]) begin
            cur = t_entry'(ram_rdata);
        end else begin
            cur = ENTRY_RST;
        end

        raw_same    = r_s1_item.raw_level == cur.last_raw;
        elapsed     = r_s1_item.time_ms - cur.change_time;
        held_time   = r_s1_item.time_ms - cur.press_start;
        // A raw change restarts the timer, so the level cannot be taken on that sample.
        level_taken = raw_same && (elapsed > 32'(r_debounce_ms))
                      && (r_s1_item.raw_level != cur.stable_level);

        wr_entry          = cur;
        wr_entry.last_raw = r_s1_item.raw_level;
        n_event           = EV_NONE;
        n_duration        = 32'd0;
        if (!raw_same) begin
            wr_entry.change_time = r_s1_item.time_ms;
        end
        if (level_taken) begin
            wr_entry.stable_level = r_s1_item.raw_level;
            if (!r_s1_item.raw_level) begin
                wr_entry.held_flag   = 1'b1;
                wr_entry.press_start = r_s1_item.time_ms;
                n_event              = EV_PRESS;
            end else if (cur.held_flag) begin
                wr_entry.held_flag = 1'b0;
                n_duration         = held_time;
                n_event = (held_time < 32'(r_long_press_ms)) ? EV_SHORT : EV_LONG;
            end
        end
        // Buttons beyond the configured count report nothing.
        if (!s1_in_range) begin
            n_event    = EV_NONE;
            n_duration = 32'd0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_item.button_id     <= r_s1_item.button_index;
            r_out_item.press_event   <= n_event;
            r_out_item.hold_duration <= n_duration;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
